// ----- rtl/rie_pkg.sv -----
// ----------------------------------------------------------------------------
// rie_pkg : shared types and constants of the RV32I integer execute block
// Command codes, stage payload structs and sizing constants.
// ----------------------------------------------------------------------------
package rie_pkg;

  localparam int unsigned Xlen       = 32;
  localparam int unsigned RegCount   = 32;
  localparam int unsigned RegIdxW    = $clog2(RegCount);
  // Depth of the data store; a power of two, so the entry is the low address bits
  localparam int unsigned StoreDepth = 1024;
  localparam int unsigned StoreIdxW  = $clog2(StoreDepth);
  localparam int unsigned CmdW       = 6;
  localparam int unsigned ImmW       = 21;
  localparam int unsigned InTdataW   = 80;
  localparam int unsigned OutTdataW  = 72;

  localparam logic [Xlen-1:0] PcStep   = 32'd4;
  localparam logic [Xlen-1:0] ByteMask = 32'h0000_00FF;
  localparam logic [Xlen-1:0] HalfMask = 32'h0000_FFFF;

  typedef enum logic [CmdW-1:0] {
    CMD_ADD   = 6'd0,  CMD_SUB   = 6'd1,  CMD_SLL  = 6'd2,  CMD_SLT   = 6'd3,
    CMD_SLTU  = 6'd4,  CMD_XOR   = 6'd5,  CMD_SRL  = 6'd6,  CMD_SRA   = 6'd7,
    CMD_OR    = 6'd8,  CMD_AND   = 6'd9,  CMD_ADDI = 6'd10, CMD_SLTI  = 6'd11,
    CMD_SLTIU = 6'd12, CMD_XORI  = 6'd13, CMD_ORI  = 6'd14, CMD_ANDI  = 6'd15,
    CMD_SLLI  = 6'd16, CMD_SRLI  = 6'd17, CMD_SRAI = 6'd18, CMD_LB    = 6'd19,
    CMD_LH    = 6'd20, CMD_LW    = 6'd21, CMD_LBU  = 6'd22, CMD_LHU   = 6'd23,
    CMD_SW    = 6'd24, CMD_SH    = 6'd25, CMD_SB   = 6'd26, CMD_BEQ   = 6'd27,
    CMD_BNE   = 6'd28, CMD_BLT   = 6'd29, CMD_BGE  = 6'd30, CMD_BLTU  = 6'd31,
    CMD_BGEU  = 6'd32, CMD_LUI   = 6'd33, CMD_JAL  = 6'd34, CMD_HALT  = 6'd35
  } cmd_e;

  // Decoded instruction held in the operand stage
  typedef struct packed {
    cmd_e               cmd;
    logic [RegIdxW-1:0] rd;
    logic [RegIdxW-1:0] rs1;
    logic [RegIdxW-1:0] rs2;
    logic [Xlen-1:0]    imm;
    logic [Xlen-1:0]    pc;
  } instr_t;

  // Execute results, from the ALU to the memory stage
  typedef struct packed {
    logic            wr;
    logic [Xlen-1:0] val;
    logic            taken;
    logic [Xlen-1:0] next_pc;
    logic            halt;
    logic            ld;
    logic            st;
    logic [Xlen-1:0] addr;
    logic [Xlen-1:0] st_data;
  } ex_t;

endpackage

// ----- rtl/rie_regfile.sv -----
// ----------------------------------------------------------------------------
// rie_regfile : 32-entry integer register file
// Two registered read ports, one write port, per-entry valid bits for reset
// and write-through bypass when a read and a write meet on the same edge.
// ----------------------------------------------------------------------------
module rie_regfile (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [rie_pkg::RegIdxW-1:0] rd_addr1_i,
  input  logic [rie_pkg::RegIdxW-1:0] rd_addr2_i,
  input  logic                        wr_en_i,
  input  logic [rie_pkg::RegIdxW-1:0] wr_addr_i,
  input  logic [rie_pkg::Xlen-1:0]    wr_data_i,
  output logic [rie_pkg::Xlen-1:0]    rd_data1_o,
  output logic [rie_pkg::Xlen-1:0]    rd_data2_o
);
  import rie_pkg::*;

  logic [Xlen-1:0]     mem [RegCount];
  logic [RegCount-1:0] valid_q;
  logic [Xlen-1:0]     rd1_q, rd2_q, byp_data_q;
  logic                vld1_q, vld2_q, byp1_q, byp2_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd1_q      <= mem[rd_addr1_i];
      rd2_q      <= mem[rd_addr2_i];
      byp_data_q <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      vld1_q  <= 1'b0;
      vld2_q  <= 1'b0;
      byp1_q  <= 1'b0;
      byp2_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        vld1_q <= valid_q[rd_addr1_i];
        vld2_q <= valid_q[rd_addr2_i];
        byp1_q <= wr_en_i && (wr_addr_i == rd_addr1_i);
        byp2_q <= wr_en_i && (wr_addr_i == rd_addr2_i);
      end
    end
  end

  // Unwritten entries, x0 among them, read as zero
  assign rd_data1_o = byp1_q ? byp_data_q : (vld1_q ? rd1_q : '0);
  assign rd_data2_o = byp2_q ? byp_data_q : (vld2_q ? rd2_q : '0);

endmodule

// ----- rtl/rie_dmem.sv -----
// ----------------------------------------------------------------------------
// rie_dmem : word-per-address data store
// Single write port, registered read, clearing sweep after reset.
// ----------------------------------------------------------------------------
module rie_dmem (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [rie_pkg::StoreIdxW-1:0] rd_idx_i,
  input  logic                          wr_en_i,
  input  logic [rie_pkg::StoreIdxW-1:0] wr_idx_i,
  input  logic [rie_pkg::Xlen-1:0]      wr_data_i,
  output logic [rie_pkg::Xlen-1:0]      rd_data_o,
  output logic                          busy_o
);
  import rie_pkg::*;

  logic [Xlen-1:0]      mem [StoreDepth];
  logic [Xlen-1:0]      rd_q;
  logic [StoreIdxW-1:0] clr_idx_q;
  logic                 clr_busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q  <= '0;
      clr_busy_q <= 1'b1;
    end else if (clr_busy_q) begin
      clr_idx_q <= clr_idx_q + 1'b1;
      if (clr_idx_q == StoreIdxW'(StoreDepth - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_idx_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = clr_busy_q;

endmodule

// ----- rtl/rie_alu.sv -----
// ----------------------------------------------------------------------------
// rie_alu : integer execute logic
// ALU operations, branch compare, next pc and load/store address.
// ----------------------------------------------------------------------------
module rie_alu (
  input  rie_pkg::instr_t          instr_i,
  input  logic [rie_pkg::Xlen-1:0] rs1_val_i,
  input  logic [rie_pkg::Xlen-1:0] rs2_val_i,
  output rie_pkg::ex_t             ex_o
);
  import rie_pkg::*;

  logic [Xlen-1:0] a, b, imm, seq_pc, tgt_pc;
  logic            lt, ltu, wr_raw, cond;
  ex_t             res;

  assign a      = rs1_val_i;
  assign b      = rs2_val_i;
  assign imm    = instr_i.imm;
  assign seq_pc = instr_i.pc + PcStep;
  assign tgt_pc = instr_i.pc + imm;
  assign lt     = $signed(a) < $signed(b);
  assign ltu    = a < b;

  always_comb begin
    res         = '0;
    wr_raw      = 1'b0;
    cond        = 1'b0;
    res.next_pc = seq_pc;
    res.addr    = a + imm;
    unique case (instr_i.cmd) inside
      CMD_ADD:   begin res.val = a + b;                       wr_raw = 1'b1; end
      CMD_SUB:   begin res.val = a - b;                       wr_raw = 1'b1; end
      CMD_SLL:   begin res.val = a << b[4:0];                 wr_raw = 1'b1; end
      CMD_SLT:   begin res.val = {31'd0, lt};                 wr_raw = 1'b1; end
      CMD_SLTU:  begin res.val = {31'd0, ltu};                wr_raw = 1'b1; end
      CMD_XOR:   begin res.val = a ^ b;                       wr_raw = 1'b1; end
      CMD_SRL:   begin res.val = a >> b[4:0];                 wr_raw = 1'b1; end
      CMD_SRA:   begin res.val = $unsigned($signed(a) >>> b[4:0]); wr_raw = 1'b1; end
      CMD_OR:    begin res.val = a | b;                       wr_raw = 1'b1; end
      CMD_AND:   begin res.val = a & b;                       wr_raw = 1'b1; end
      CMD_ADDI:  begin res.val = a + imm;                     wr_raw = 1'b1; end
      CMD_SLTI:  begin
        res.val = {31'd0, $signed(a) < $signed(imm)};
        wr_raw  = 1'b1;
      end
      CMD_SLTIU: begin res.val = {31'd0, a < imm};            wr_raw = 1'b1; end
      CMD_XORI:  begin res.val = a ^ imm;                     wr_raw = 1'b1; end
      CMD_ORI:   begin res.val = a | imm;                     wr_raw = 1'b1; end
      CMD_ANDI:  begin res.val = a & imm;                     wr_raw = 1'b1; end
      CMD_SLLI:  begin res.val = a << imm[4:0];               wr_raw = 1'b1; end
      CMD_SRLI:  begin res.val = a >> imm[4:0];               wr_raw = 1'b1; end
      CMD_SRAI:  begin res.val = $unsigned($signed(a) >>> imm[4:0]); wr_raw = 1'b1; end
      CMD_LB, CMD_LH, CMD_LW, CMD_LBU, CMD_LHU: begin
        res.ld = 1'b1;
        wr_raw = 1'b1;
      end
      CMD_SW:    begin res.st = 1'b1; res.st_data = b;            end
      CMD_SH:    begin res.st = 1'b1; res.st_data = b & HalfMask; end
      CMD_SB:    begin res.st = 1'b1; res.st_data = b & ByteMask; end
      CMD_BEQ, CMD_BNE, CMD_BLT, CMD_BGE, CMD_BLTU, CMD_BGEU: begin
        unique case (instr_i.cmd) inside
          CMD_BEQ:  cond = (a == b);
          CMD_BNE:  cond = (a != b);
          CMD_BLT:  cond = lt;
          CMD_BGE:  cond = !lt;
          CMD_BLTU: cond = ltu;
          default:  cond = !ltu;
        endcase
        res.taken = cond;
        if (cond) begin
          res.next_pc = tgt_pc;
        end
      end
      CMD_LUI:   begin res.val = imm << 12; wr_raw = 1'b1; end
      CMD_JAL:   begin
        res.val     = seq_pc;
        wr_raw      = 1'b1;
        res.taken   = 1'b1;
        res.next_pc = tgt_pc;
      end
      CMD_HALT:  begin
        res.halt    = 1'b1;
        res.next_pc = instr_i.pc;
      end
      default: ;
    endcase
    // x0 is never written
    res.wr = wr_raw && (instr_i.rd != '0);
    ex_o   = res;
  end

endmodule

// ----- rtl/rv32i_integer_execute.sv -----
// ----------------------------------------------------------------------------
// Path: input transfer to result via the operand, memory and output registers.
// Throughput: one instruction per cycle, dependent ones included, while the
//   receiver is ready; memory stage results are forwarded to the operand stage.
// Reset: asynchronous, active low; register file reads zero via valid bits,
//   the data store's 1024 entries are swept to zero with s_axis_tready_o low.
// ----------------------------------------------------------------------------
// rv32i_integer_execute : RV32I integer execute block
// Executes one decoded instruction per transfer against a register file and
// a data store, returning register write, branch outcome, next pc and halt.
// ----------------------------------------------------------------------------
module rv32i_integer_execute (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command[5:0], dest_reg[10:6], src1_reg[15:11], src2_reg[20:16],
  // immediate[41:21], pc[73:42], zero pad[79:74]
  input  logic [rie_pkg::InTdataW-1:0]     s_axis_tdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // writes_reg[0], write_index[5:1], write_value[37:6], branch_taken[38],
  // next_pc[70:39], halted[71]
  output logic [rie_pkg::OutTdataW-1:0]    m_axis_tdata_o,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i
);
  import rie_pkg::*;

  // Memory stage payload
  typedef struct packed {
    cmd_e               cmd;
    logic               wr;
    logic               ld;
    logic [RegIdxW-1:0] rd;
    logic [Xlen-1:0]    val;
    logic               taken;
    logic [Xlen-1:0]    next_pc;
    logic               halt;
  } mem_stage_t;

  function automatic logic [Xlen-1:0] load_format(cmd_e cmd, logic [Xlen-1:0] w);
    logic [Xlen-1:0] r;
    unique case (cmd) inside
      CMD_LB:  r = {{24{w[7]}}, w[7:0]};
      CMD_LH:  r = {{16{w[15]}}, w[15:0]};
      CMD_LBU: r = w & ByteMask;
      CMD_LHU: r = w & HalfMask;
      default: r = w;
    endcase
    return r;
  endfunction

  // Flow control: each stage takes a new transfer when it is empty or moving on
  logic out_ready, s2_free, s1_free, s1_go, s2_go, accept, clearing;

  logic       s1_v_q, s2_v_q, out_v_q;
  instr_t     s1_q, in_instr;
  mem_stage_t s2_q;
  ex_t        ex;

  logic [Xlen-1:0] rf_a, rf_b, op_a, op_b, dmem_rdata, s2_val;
  logic            fwd_a, fwd_b;

  logic            out_wr_q, out_taken_q, out_halt_q;
  logic [RegIdxW-1:0] out_idx_q;
  logic [Xlen-1:0] out_val_q, out_pc_q;

  assign out_ready = !out_v_q || m_axis_tready_i;
  assign s2_free   = !s2_v_q || out_ready;
  assign s1_free   = !s1_v_q || s2_free;
  assign s1_go     = s1_v_q && s2_free;
  assign s2_go     = s2_v_q && out_ready;

  // Hold the input off while the data store is being cleared
  assign s_axis_tready_o = s1_free && !clearing;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  // Unpack the incoming transfer
  always_comb begin
    in_instr.cmd = cmd_e'(s_axis_tdata_i[5:0]);
    in_instr.rd  = s_axis_tdata_i[10:6];
    in_instr.rs1 = s_axis_tdata_i[15:11];
    in_instr.rs2 = s_axis_tdata_i[20:16];
    in_instr.imm = {{(Xlen - ImmW){s_axis_tdata_i[41]}}, s_axis_tdata_i[41:21]};
    in_instr.pc  = s_axis_tdata_i[73:42];
  end

  // Register file: read on the accepting edge, write as the memory stage drains
  rie_regfile u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (accept),
    .rd_addr1_i (in_instr.rs1),
    .rd_addr2_i (in_instr.rs2),
    .wr_en_i    (s2_go && s2_q.wr),
    .wr_addr_i  (s2_q.rd),
    .wr_data_i  (s2_val),
    .rd_data1_o (rf_a),
    .rd_data2_o (rf_b)
  );

  // Forward the memory stage's result, not yet in the register file
  assign s2_val = s2_q.ld ? load_format(s2_q.cmd, dmem_rdata) : s2_q.val;
  assign fwd_a  = s2_v_q && s2_q.wr && (s2_q.rd == s1_q.rs1);
  assign fwd_b  = s2_v_q && s2_q.wr && (s2_q.rd == s1_q.rs2);
  assign op_a   = fwd_a ? s2_val : rf_a;
  assign op_b   = fwd_b ? s2_val : rf_b;

  rie_alu u_alu (
    .instr_i   (s1_q),
    .rs1_val_i (op_a),
    .rs2_val_i (op_b),
    .ex_o      (ex)
  );

  // Stores write and loads read as the instruction leaves the operand stage
  rie_dmem u_dmem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s1_go && ex.ld),
    .rd_idx_i  (ex.addr[StoreIdxW-1:0]),
    .wr_en_i   (s1_go && ex.st),
    .wr_idx_i  (ex.addr[StoreIdxW-1:0]),
    .wr_data_i (ex.st_data),
    .rd_data_o (dmem_rdata),
    .busy_o    (clearing)
  );

  // Stage valids
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_v_q <= accept;
      end
      if (s2_free) begin
        s2_v_q <= s1_v_q;
      end
      if (out_ready) begin
        out_v_q <= s2_v_q;
      end
    end
  end

  // Stage payloads; hold while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= in_instr;
    end
    if (s1_go) begin
      s2_q.cmd     <= s1_q.cmd;
      s2_q.wr      <= ex.wr;
      s2_q.ld      <= ex.ld;
      s2_q.rd      <= s1_q.rd;
      s2_q.val     <= ex.val;
      s2_q.taken   <= ex.taken;
      s2_q.next_pc <= ex.next_pc;
      s2_q.halt    <= ex.halt;
    end
    if (s2_go) begin
      out_wr_q    <= s2_q.wr;
      out_idx_q   <= s2_q.wr ? s2_q.rd : '0;
      out_val_q   <= s2_q.wr ? s2_val : '0;
      out_taken_q <= s2_q.taken;
      out_pc_q    <= s2_q.next_pc;
      out_halt_q  <= s2_q.halt;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = {out_halt_q, out_pc_q, out_taken_q, out_val_q, out_idx_q,
                            out_wr_q};

endmodule

// ----- tb/rv32i_integer_execute_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rv32i_integer_execute_tb : self-checking bench for the RV32I execute block
// Drives decoded instructions over the input stream and keeps its own
// register file and data store to predict every result transfer. It runs
// directed corner cases of the ALU, loads, stores, branches, jumps and halt,
// then random traffic under three sender/receiver stall patterns.
// ----------------------------------------------------------------------------
module rv32i_integer_execute_tb;
  import rie_pkg::*;

  // Codes outside the decoded set; the block must treat them as no-ops
  localparam logic [CmdW-1:0] CmdUnusedLo = 6'd36;
  localparam logic [CmdW-1:0] CmdUnusedHi = 6'd63;

  // The reset sweep of the data store runs with no transfer; StallLimit allows for it
  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ResetCycles = 12;

  typedef struct {
    logic [CmdW-1:0]    cmd;
    logic [RegIdxW-1:0] rd;
    logic [RegIdxW-1:0] rs1;
    logic [RegIdxW-1:0] rs2;
    logic [ImmW-1:0]    imm;
    logic [Xlen-1:0]    pc;
  } instr_item_t;

  typedef struct {
    logic               writes_reg;
    logic [RegIdxW-1:0] write_index;
    logic [Xlen-1:0]    write_value;
    logic               branch_taken;
    logic [Xlen-1:0]    next_pc;
    logic               halted;
  } exec_result_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic [InTdataW-1:0]  s_axis_tdata = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OutTdataW-1:0] m_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;

  // Architectural state as the bench sees it
  logic [Xlen-1:0] arch_regs  [RegCount];
  logic [Xlen-1:0] arch_store [StoreDepth];

  exec_result_t pending_results [$];

  int unsigned src_idle_pct  = 20;
  int unsigned sink_idle_pct = 74;
  int unsigned instr_count   = 0;
  int unsigned result_count  = 0;
  int unsigned mismatch_count = 0;
  int unsigned taken_count   = 0;
  int unsigned mem_op_count  = 0;

  rv32i_integer_execute u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Execute one instruction against the bench state and return its result
  function automatic exec_result_t execute_instr(instr_item_t it);
    exec_result_t        r;
    logic [Xlen-1:0]     a;
    logic [Xlen-1:0]     b;
    logic [Xlen-1:0]     imm32;
    logic [Xlen-1:0]     addr;
    logic [Xlen-1:0]     word;
    logic [Xlen-1:0]     val;
    logic                wr;
    logic                cond;
    logic [StoreIdxW-1:0] entry;
    a     = (it.rs1 == '0) ? '0 : arch_regs[it.rs1];
    b     = (it.rs2 == '0) ? '0 : arch_regs[it.rs2];
    imm32 = {{(Xlen-ImmW){it.imm[ImmW-1]}}, it.imm};
    addr  = a + imm32;
    entry = addr[StoreIdxW-1:0];
    word  = arch_store[entry];
    val   = '0;
    wr    = 1'b0;
    cond  = 1'b0;
    r.branch_taken = 1'b0;
    r.halted       = 1'b0;
    r.next_pc      = it.pc + PcStep;
    case (it.cmd)
      CMD_ADD:   begin val = a + b; wr = 1'b1; end
      CMD_SUB:   begin val = a - b; wr = 1'b1; end
      CMD_SLL:   begin val = a << b[4:0]; wr = 1'b1; end
      CMD_SLT:   begin val = {31'b0, $signed(a) < $signed(b)}; wr = 1'b1; end
      CMD_SLTU:  begin val = {31'b0, a < b}; wr = 1'b1; end
      CMD_XOR:   begin val = a ^ b; wr = 1'b1; end
      CMD_SRL:   begin val = a >> b[4:0]; wr = 1'b1; end
      CMD_SRA:   begin val = $signed(a) >>> b[4:0]; wr = 1'b1; end
      CMD_OR:    begin val = a | b; wr = 1'b1; end
      CMD_AND:   begin val = a & b; wr = 1'b1; end
      CMD_ADDI:  begin val = a + imm32; wr = 1'b1; end
      CMD_SLTI:  begin val = {31'b0, $signed(a) < $signed(imm32)}; wr = 1'b1; end
      CMD_SLTIU: begin val = {31'b0, a < imm32}; wr = 1'b1; end
      CMD_XORI:  begin val = a ^ imm32; wr = 1'b1; end
      CMD_ORI:   begin val = a | imm32; wr = 1'b1; end
      CMD_ANDI:  begin val = a & imm32; wr = 1'b1; end
      CMD_SLLI:  begin val = a << imm32[4:0]; wr = 1'b1; end
      CMD_SRLI:  begin val = a >> imm32[4:0]; wr = 1'b1; end
      CMD_SRAI:  begin val = $signed(a) >>> imm32[4:0]; wr = 1'b1; end
      CMD_LB:    begin val = {{24{word[7]}}, word[7:0]}; wr = 1'b1; end
      CMD_LH:    begin val = {{16{word[15]}}, word[15:0]}; wr = 1'b1; end
      CMD_LW:    begin val = word; wr = 1'b1; end
      CMD_LBU:   begin val = word & ByteMask; wr = 1'b1; end
      CMD_LHU:   begin val = word & HalfMask; wr = 1'b1; end
      // Narrow stores replace the whole word, zero-extended
      CMD_SW:    arch_store[entry] = b;
      CMD_SH:    arch_store[entry] = b & HalfMask;
      CMD_SB:    arch_store[entry] = b & ByteMask;
      CMD_BEQ:   cond = (a == b);
      CMD_BNE:   cond = (a != b);
      CMD_BLT:   cond = ($signed(a) < $signed(b));
      CMD_BGE:   cond = ($signed(a) >= $signed(b));
      CMD_BLTU:  cond = (a < b);
      CMD_BGEU:  cond = (a >= b);
      CMD_LUI:   begin val = imm32 << 12; wr = 1'b1; end
      CMD_JAL: begin
        val = it.pc + PcStep;
        wr  = 1'b1;
        r.branch_taken = 1'b1;
        r.next_pc      = it.pc + imm32;
      end
      CMD_HALT: begin
        r.halted  = 1'b1;
        r.next_pc = it.pc;
      end
      default: ;
    endcase
    if (cond) begin
      r.branch_taken = 1'b1;
      r.next_pc      = it.pc + imm32;
    end
    // x0 is never written and the result reports no write
    if (wr && it.rd != '0) begin
      arch_regs[it.rd] = val;
      r.writes_reg  = 1'b1;
      r.write_index = it.rd;
      r.write_value = val;
    end else begin
      r.writes_reg  = 1'b0;
      r.write_index = '0;
      r.write_value = '0;
    end
    return r;
  endfunction

  // Offer one instruction, idling first at the sender's rate; return on the transfer
  task automatic issue_instr(input logic [CmdW-1:0] cmd, input logic [RegIdxW-1:0] rd,
                             input logic [RegIdxW-1:0] rs1, input logic [RegIdxW-1:0] rs2,
                             input logic [ImmW-1:0] imm, input logic [Xlen-1:0] pc);
    instr_item_t  it;
    exec_result_t r;
    it.cmd = cmd;
    it.rd  = rd;
    it.rs1 = rs1;
    it.rs2 = rs2;
    it.imm = imm;
    it.pc  = pc;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= {{(InTdataW-74){1'b0}}, pc, imm, rs2, rs1, rd, cmd};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    r = execute_instr(it);
    pending_results.push_back(r);
    instr_count++;
    if (r.branch_taken) taken_count++;
    if (cmd >= CMD_LB && cmd <= CMD_SB) mem_op_count++;
  endtask

  // Hold the sender off until every outstanding result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic flag_mismatch(input string field, input logic [Xlen-1:0] got,
                               input logic [Xlen-1:0] want);
    $display("%0t: result %0d: %s is %h, expected %h", $realtime, result_count, field,
             got, want);
    mismatch_count++;
  endtask

  // Receiver: stall at the current rate
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // Compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    exec_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (pending_results.size() == 0) begin
        flag_mismatch("unexpected result", m_axis_tdata[Xlen-1:0], '0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[0] !== want.writes_reg)
          flag_mismatch("writes_reg", Xlen'(m_axis_tdata[0]), Xlen'(want.writes_reg));
        if (m_axis_tdata[5:1] !== want.write_index)
          flag_mismatch("write_index", Xlen'(m_axis_tdata[5:1]), Xlen'(want.write_index));
        if (m_axis_tdata[37:6] !== want.write_value)
          flag_mismatch("write_value", m_axis_tdata[37:6], want.write_value);
        if (m_axis_tdata[38] !== want.branch_taken)
          flag_mismatch("branch_taken", Xlen'(m_axis_tdata[38]), Xlen'(want.branch_taken));
        if (m_axis_tdata[70:39] !== want.next_pc)
          flag_mismatch("next_pc", m_axis_tdata[70:39], want.next_pc);
        if (m_axis_tdata[71] !== want.halted)
          flag_mismatch("halted", Xlen'(m_axis_tdata[71]), Xlen'(want.halted));
      end
    end
  end

  // Watchdog: give up after a long stretch with no transfer on either side
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Watchdog: no transfer for %0d cycles", StallLimit);
    $display("Regression FAIL");
    $finish;
  end

  // Wrapping arithmetic, compares at the sign boundary, shift amounts from low bits
  task automatic test_alu_corners();
    issue_instr(CMD_LUI,   5'd1,  5'd0, 5'd0, 21'h100000, 32'h0000_0000);
    issue_instr(CMD_ADDI,  5'd3,  5'd0, 5'd0, -21'sd1,    32'h0000_0004);
    issue_instr(CMD_LUI,   5'd2,  5'd0, 5'd0, 21'h0FFFFF, 32'h0000_0008);
    issue_instr(CMD_ADD,   5'd4,  5'd1, 5'd3, 21'h0,      32'h0000_000C);
    issue_instr(CMD_SUB,   5'd5,  5'd0, 5'd1, 21'h0,      32'h0000_0010);
    issue_instr(CMD_SLL,   5'd6,  5'd3, 5'd3, 21'h0,      32'h0000_0014);
    issue_instr(CMD_SLTU,  5'd8,  5'd1, 5'd4, 21'h0,      32'h0000_0018);
    issue_instr(CMD_SRA,   5'd11, 5'd1, 5'd3, 21'h0,      32'h0000_001C);
    issue_instr(CMD_SLTIU, 5'd15, 5'd4, 5'd0, -21'sd1,    32'h0000_0020);
    issue_instr(CMD_SRLI,  5'd20, 5'd1, 5'd0, 21'h3F,     32'h0000_0024);
    // destination x0: no write reported
    issue_instr(CMD_ADD,   5'd0,  5'd3, 5'd3, 21'h0,      32'h0000_0028);
  endtask

  // Address wrap onto one entry, narrow stores, sign and zero extending loads
  task automatic test_load_store_corners();
    issue_instr(CMD_SW,  5'd0,  5'd0, 5'd3, 21'd1029,   32'h0000_0100);
    issue_instr(CMD_LB,  5'd13, 5'd0, 5'd0, 21'd5,      32'h0000_0104);
    issue_instr(CMD_LH,  5'd12, 5'd0, 5'd0, 21'd5,      32'h0000_0108);
    issue_instr(CMD_LBU, 5'd14, 5'd0, 5'd0, 21'd5,      32'h0000_010C);
    issue_instr(CMD_SH,  5'd0,  5'd0, 5'd4, -21'sd1019, 32'h0000_0110);
    issue_instr(CMD_LHU, 5'd16, 5'd0, 5'd0, 21'd5,      32'h0000_0114);
    issue_instr(CMD_SB,  5'd0,  5'd0, 5'd3, 21'd5,      32'h0000_0118);
    issue_instr(CMD_LW,  5'd17, 5'd0, 5'd0, 21'd5,      32'h0000_011C);
  endtask

  // Every branch, taken and not, target wrap, JAL link wrap, halt and an unused code
  task automatic test_branch_jump_corners();
    issue_instr(CMD_BEQ,     5'd0, 5'd3, 5'd3, -21'sd4,    32'h0000_0000);
    issue_instr(CMD_BNE,     5'd0, 5'd0, 5'd0, 21'd64,     32'h0000_0200);
    issue_instr(CMD_BLT,     5'd0, 5'd1, 5'd4, 21'h0FFFFF, 32'h8000_0000);
    issue_instr(CMD_BGE,     5'd0, 5'd1, 5'd4, 21'd8,      32'h0000_0204);
    issue_instr(CMD_BLTU,    5'd0, 5'd4, 5'd1, 21'h100000, 32'h0000_0208);
    issue_instr(CMD_BGEU,    5'd0, 5'd0, 5'd3, 21'd8,      32'h0000_020C);
    issue_instr(CMD_JAL,     5'd1, 5'd0, 5'd0, 21'd8,      32'hFFFF_FFFC);
    issue_instr(CMD_HALT,    5'd7, 5'd1, 5'd2, 21'd12,     32'hFFFF_FFFF);
    issue_instr(CmdUnusedHi, 5'd9, 5'd1, 5'd2, 21'd16,     32'h1234_5678);
  endtask

  // Mostly dependent instruction streams over a small register window,
  // half of the loads and stores packed onto low entries so they meet each other
  task automatic issue_random_instr();
    logic [CmdW-1:0]    cmd;
    logic [RegIdxW-1:0] rd;
    logic [RegIdxW-1:0] rs1;
    logic [RegIdxW-1:0] rs2;
    logic [ImmW-1:0]    imm;
    logic [Xlen-1:0]    pc;
    int unsigned        sel;
    sel = $urandom_range(99);
    if ($urandom_range(99) < 60) begin
      rd  = RegIdxW'($urandom_range(7));
      rs1 = RegIdxW'($urandom_range(7));
      rs2 = RegIdxW'($urandom_range(7));
    end else begin
      rd  = RegIdxW'($urandom);
      rs1 = RegIdxW'($urandom);
      rs2 = RegIdxW'($urandom);
    end
    case ($urandom_range(9))
      0:       imm = 21'h100000;
      1:       imm = 21'h0FFFFF;
      2:       imm = '1;
      3:       imm = '0;
      4, 5, 6: imm = ImmW'($urandom_range(63));
      default: imm = ImmW'($urandom);
    endcase
    if ($urandom_range(9) == 0) pc = 32'hFFFF_FFF0 | ($urandom_range(3) << 2);
    else pc = $urandom;
    if (sel < 5) begin
      cmd = CMD_LUI;
    end else if (sel < 45) begin
      cmd = CmdW'($urandom_range(CMD_SRAI, CMD_ADD));
    end else if (sel < 70) begin
      cmd = CmdW'($urandom_range(CMD_SB, CMD_LB));
      if ($urandom_range(1)) begin
        rs1 = '0;
        // low entries, reached directly or through a wrapped negative offset
        if ($urandom_range(1)) imm = ImmW'($urandom_range(31));
        else imm = ImmW'($urandom_range(31) - StoreDepth);
      end
    end else if (sel < 88) begin
      cmd = CmdW'($urandom_range(CMD_BGEU, CMD_BEQ));
      if ($urandom_range(3) == 0) rs2 = rs1;
    end else if (sel < 94) begin
      cmd = CMD_JAL;
    end else if (sel < 98) begin
      cmd = CMD_HALT;
    end else begin
      cmd = CmdW'($urandom_range(CmdUnusedHi, CmdUnusedLo));
    end
    issue_instr(cmd, rd, rs1, rs2, imm, pc);
  endtask

  // Random traffic at one stall pattern; stop halfway once and let everything drain
  task automatic test_random_traffic(input int unsigned count, input int unsigned src_pct,
                                     input int unsigned sink_pct);
    src_idle_pct  = src_pct;
    sink_idle_pct = sink_pct;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) drain_results();
      issue_random_instr();
    end
    drain_results();
  endtask

  initial begin
    // Start from the cleared state that reset gives the block
    foreach (arch_regs[i]) arch_regs[i] = '0;
    foreach (arch_store[i]) arch_store[i] = '0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_alu_corners();
    test_load_store_corners();
    test_branch_jump_corners();
    drain_results();

    test_random_traffic(560, 20, 74);
    test_random_traffic(560, 74, 20);
    test_random_traffic(560, 0, 0);

    $display("Sent %0d instructions, checked %0d results: %0d loads/stores, %0d taken",
             instr_count, result_count, mem_op_count, taken_count);
    $display("Three stall patterns with forced drains; %0d field mismatches",
             mismatch_count);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/rie_pkg.sv
rtl/rie_regfile.sv
rtl/rie_dmem.sv
rtl/rie_alu.sv
rtl/rv32i_integer_execute.sv
tb/rv32i_integer_execute_tb.sv
